// ===== src/masked_byte_pattern_scan_core_defines.svh =====
// Assertion macros shared by the scan core modules.
`ifndef MASKED_BYTE_PATTERN_SCAN_CORE_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCAN_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBPS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mbps: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MBPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mbps: next-cycle check failed");

`endif

// ===== src/mbps_pkg.sv =====
// Package with types and constants of the masked byte pattern scan core.
`timescale 1ns / 1ps
package mbps_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 5;
  localparam int CARE_W     = 16;
  localparam int PAT_W      = 128;
  localparam int OFFSET_W   = 32;
  localparam int ADDR_W     = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_REGION_BASE  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [PAT_W-1:0]  pattern;
    logic [CARE_W-1:0] care;
    logic [LEN_W-1:0]  length;
  } scan_cfg_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } result_req_t;

endpackage

// ===== src/mbps_front.sv =====
// Front end: byte window, offset counter and parallel masked compare.
`timescale 1ns / 1ps
`include "masked_byte_pattern_scan_core_defines.svh"
module mbps_front import mbps_pkg::*; #(
  parameter int PatternMax = PATTERN_MAX_DEF,
  parameter int OffsetBits = OFFSET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  scan_cfg_t   cfg_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        full_i,
  output logic        push_o,
  output result_req_t req_o
);

  localparam int CntW    = (OffsetBits < 32) ? OffsetBits : 32;
  localparam int WinIdxW = (PatternMax > 1) ? $clog2(PatternMax) : 1;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  logic [7:0]      win_q [PatternMax];
  logic [7:0]      win_d [PatternMax];
  logic [CntW-1:0] seen_q, seen_inc;
  logic            latched_q;
  logic [LEN_W-1:0] len;
  logic [PatternMax-1:0] miss;
  logic [CntW-1:0] off;
  logic            hit, accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    if (cfg_i.length == '0) begin
      len = LEN_W'(1);
    end else if (cfg_i.length > LEN_W'(PatternMax)) begin
      len = LEN_W'(PatternMax);
    end else begin
      len = cfg_i.length;
    end
  end

  always_comb begin
    win_d[0] = data_byte_i;
    for (int k = 1; k < PatternMax; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  assign seen_inc = (seen_q == CntMax) ? seen_q : seen_q + CntW'(1);

  always_comb begin
    logic [LEN_W-1:0] pos;
    for (int j = 0; j < PatternMax; j++) begin
      pos = len - LEN_W'(1) - LEN_W'(j);
      miss[j] = (LEN_W'(j) < len) && cfg_i.care[j] &&
                (win_d[pos[WinIdxW-1:0]] != cfg_i.pattern[8*j +: 8]);
    end
  end

  assign hit = (seen_inc >= CntW'(len)) && (miss == '0);
  assign off = seen_inc - CntW'(len);

  assign push_o       = accept && !latched_q && (hit || last_byte_i);
  assign req_o.found  = hit;
  assign req_o.offset = hit ? OFFSET_W'(off) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PatternMax; k++) begin
        win_q[k] <= '0;
      end
      seen_q    <= '0;
      latched_q <= 1'b0;
    end else if (accept) begin
      if (last_byte_i) begin
        for (int k = 0; k < PatternMax; k++) begin
          win_q[k] <= '0;
        end
        seen_q    <= '0;
        latched_q <= 1'b0;
      end else if (!latched_q) begin
        for (int k = 0; k < PatternMax; k++) begin
          win_q[k] <= win_d[k];
        end
        seen_q <= seen_inc;
        if (hit) begin
          latched_q <= 1'b1;
        end
      end
    end
  end

  `MBPS_ASSERT_SAME(a_no_push_when_full, clk_i, rst_ni, push_o, !full_i)
  `MBPS_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, accept && last_byte_i,
                    seen_q == '0 && !latched_q)
  `MBPS_ASSERT_NEXT(a_hit_latches, clk_i, rst_ni,
                    accept && hit && !latched_q && !last_byte_i, latched_q)

endmodule

// ===== src/mbps_queue.sv =====
// Short result queue between the front end and the back end.
`timescale 1ns / 1ps
`include "masked_byte_pattern_scan_core_defines.svh"
module mbps_queue import mbps_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  result_req_t push_data_i,
  output logic        full_o,
  output logic        valid_o,
  input  logic        pop_i,
  output result_req_t pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  result_req_t       mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `MBPS_ASSERT_SAME(a_pop_not_empty, clk_i, rst_ni, pop_i, count_q != '0)

endmodule

// ===== src/mbps_back.sv =====
// Back end: address computation and the registered result output.
`timescale 1ns / 1ps
`include "masked_byte_pattern_scan_core_defines.svh"
module mbps_back import mbps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ADDR_W-1:0]   region_base_i,
  input  logic                req_valid_i,
  input  result_req_t         req_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                match_found_o,
  output logic [OFFSET_W-1:0] match_offset_o,
  output logic [ADDR_W-1:0]   match_address_o
);

  logic                out_valid_q;
  logic                found_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [ADDR_W-1:0]   addr_q, addr_d;

  assign pop_o  = req_valid_i && (!out_valid_q || !out_stall_i);
  assign addr_d = req_i.found ? region_base_i + ADDR_W'(req_i.offset) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      found_q  <= req_i.found;
      offset_q <= req_i.offset;
      addr_q   <= addr_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign match_found_o   = found_q;
  assign match_offset_o  = offset_q;
  assign match_address_o = addr_q;

  `MBPS_ASSERT_SAME(a_not_found_zero, clk_i, rst_ni, out_valid_q && !found_q,
                    offset_q == '0 && addr_q == '0)

endmodule

// ===== src/masked_byte_pattern_scan_core.sv =====
// Top level of the masked byte pattern scan core.
`timescale 1ns / 1ps
// Scans a region one byte per clock: until the first match, each byte shifts into
// a window of the last PatternMax bytes, which is compared against the masked
// pattern combinationally, and that combinational window compare sets the rate.
// The block takes a byte every cycle while the two-entry result queue has room.
// A result passes from the result queue into the output register, and leaves it.
// Configuration writes are always taken and should be made between regions.
module masked_byte_pattern_scan_core import mbps_pkg::*; #(
  parameter int PatternMax = PATTERN_MAX_DEF,
  parameter int OffsetBits = OFFSET_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  match_found_o,
  output logic [OFFSET_W-1:0]   match_offset_o,
  output logic [ADDR_W-1:0]     match_address_o
);

  logic [63:0]       pat_low_q, pat_high_q;
  logic [CARE_W-1:0] care_q;
  logic [LEN_W-1:0]  len_q;
  logic [ADDR_W-1:0] base_q;
  scan_cfg_t         scan_cfg;
  logic              push, full, req_valid, pop;
  result_req_t       push_req, pop_req;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      care_q     <= '1;
      len_q      <= LEN_W'(1);
      base_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PATTERN_LOW:  pat_low_q  <= cfg_data_i;
        REG_PATTERN_HIGH: pat_high_q <= cfg_data_i;
        REG_CARE_MASK:    care_q     <= cfg_data_i[CARE_W-1:0];
        REG_PATTERN_LEN:  len_q      <= cfg_data_i[LEN_W-1:0];
        REG_REGION_BASE:  base_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign scan_cfg.pattern = {pat_high_q, pat_low_q};
  assign scan_cfg.care    = care_q;
  assign scan_cfg.length  = len_q;

  mbps_front #(
    .PatternMax(PatternMax),
    .OffsetBits(OffsetBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (scan_cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .full_i     (full),
    .push_o     (push),
    .req_o      (push_req)
  );

  mbps_queue #(
    .Depth(QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_req),
    .full_o     (full),
    .valid_o    (req_valid),
    .pop_i      (pop),
    .pop_data_o (pop_req)
  );

  mbps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .region_base_i  (base_q),
    .req_valid_i    (req_valid),
    .req_i          (pop_req),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .match_found_o  (match_found_o),
    .match_offset_o (match_offset_o),
    .match_address_o(match_address_o)
  );

endmodule

// ===== dv/masked_byte_pattern_scan_core_tb.sv =====
// Self-checking testbench for the masked byte pattern scan core.
`timescale 1ns / 1ps
module masked_byte_pattern_scan_core_tb;
  import mbps_pkg::*;

  localparam int SCAN_ITEMS    = 1300;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int UNUSED_IDX_LO = int'(REG_REGION_BASE) + 1;
  localparam int UNUSED_IDX_HI = (1 << CFG_IDX_W) - 1;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
    logic [ADDR_W-1:0]   address;
  } scan_result_t;

  typedef enum int {STALL_NONE, STALL_SCATTER, STALL_RUNS} stall_mode_e;

  class scan_scoreboard;
    logic [PAT_W-1:0]    pattern;
    logic [CARE_W-1:0]   care;
    logic [LEN_W-1:0]    length_reg;
    logic [ADDR_W-1:0]   base;
    logic [7:0]          window [PATTERN_MAX_DEF];
    logic [OFFSET_W-1:0] seen;
    bit                  latched;
    scan_result_t        pending_q[$];
    int unsigned         scanned;
    int unsigned         mismatches;

    function new();
      pattern    = '0;
      care       = '1;
      length_reg = 1;
      base       = '0;
      scanned    = 0;
      mismatches = 0;
      clear_region();
    endfunction

    function void clear_region();
      foreach (window[k]) window[k] = '0;
      seen    = '0;
      latched = 1'b0;
    endfunction

    function int effective_length();
      if (length_reg == 0) return 1;
      if (length_reg > PATTERN_MAX_DEF) return PATTERN_MAX_DEF;
      return int'(length_reg);
    endfunction

    function void queue_result(scan_result_t r);
      pending_q = {pending_q, r};
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PATTERN_LOW:  pattern[63:0]   = data;
        REG_PATTERN_HIGH: pattern[127:64] = data;
        REG_CARE_MASK:    care            = data[CARE_W-1:0];
        REG_PATTERN_LEN:  length_reg      = data[LEN_W-1:0];
        REG_REGION_BASE:  base            = data;
        default: ;
      endcase
    endfunction

    // Notes one accepted byte and queues the result it causes, if any.
    function void note_byte(logic [7:0] b, logic last);
      int                  len;
      bit                  hit;
      logic [OFFSET_W-1:0] off;
      scanned++;
      if (!latched) begin
        len = effective_length();
        for (int k = PATTERN_MAX_DEF - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = b;
        if (seen != '1) seen++;
        hit = (seen >= len);
        for (int j = 0; j < len; j++) begin
          if (care[j] && window[len-1-j] != pattern[8*j +: 8]) hit = 1'b0;
        end
        if (hit) begin
          off     = seen - len;
          latched = 1'b1;
          queue_result(scan_result_t'{1'b1, off, base + ADDR_W'(off)});
        end else if (last) begin
          queue_result(scan_result_t'{1'b0, '0, '0});
        end
      end
      if (last) clear_region();
    endfunction

    function void check_result(scan_result_t got);
      scan_result_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0d offset=%0h address=%0h",
                   got.found, got.offset, got.address);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.found !== exp_r.found || got.offset !== exp_r.offset ||
          got.address !== exp_r.address) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected found=%0d offset=%0h address=%0h, ",
                    "got found=%0d offset=%0h address=%0h"},
                   exp_r.found, exp_r.offset, exp_r.address,
                   got.found, got.offset, got.address);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i = '0;
  logic                  last_byte_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  match_found_o;
  logic [OFFSET_W-1:0]   match_offset_o;
  logic [ADDR_W-1:0]     match_address_o;

  scan_scoreboard board;
  logic [7:0]     region_q[$];
  int             burst_left = 0;
  stall_mode_e    stall_mode = STALL_NONE;
  int             stall_run = 0;
  int             mode_timer = 0;
  int unsigned    cycle_count = 0;

  function automatic void append_byte(input logic [7:0] b);
    region_q = {region_q, b};
  endfunction

  masked_byte_pattern_scan_core dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .data_byte_i,
    .last_byte_i,
    .out_valid_o,
    .out_stall_i,
    .match_found_o,
    .match_offset_o,
    .match_address_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("masked_byte_pattern_scan_core verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (mode_timer == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      mode_timer <= $urandom_range(50, 400);
    end else begin
      mode_timer <= mode_timer - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall_i <= 1'b0;
      STALL_SCATTER: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_run != 0) begin
          out_stall_i <= 1'b1;
          stall_run   <= stall_run - 1;
        end else if ($urandom_range(0, 5) == 0) begin
          out_stall_i <= 1'b1;
          stall_run   <= $urandom_range(1, 24);
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(scan_result_t'{match_found_o, match_offset_o, match_address_o});
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    board.note_byte(b, last);
    burst_left--;
  endtask

  task automatic send_region();
    foreach (region_q[i]) send_byte(region_q[i], i == region_q.size() - 1);
    region_q.delete();
  endtask

  // Waits until every queued result has been taken and the pipeline has emptied.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
  endtask

  task automatic program_scan(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [CARE_W-1:0] care, input logic [LEN_W-1:0] len,
                              input logic [ADDR_W-1:0] base);
    logic [63:0] len_word;
    drain();
    len_word = ({$urandom, $urandom} & ~64'(5'h1f)) | 64'(len);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_CARE_MASK, {{$urandom, $urandom}} & ~64'(16'hffff) | 64'(care));
    write_reg(REG_PATTERN_LEN, len_word);
    write_reg(REG_REGION_BASE, base);
    write_reg(CFG_IDX_W'($urandom_range(UNUSED_IDX_LO, UNUSED_IDX_HI)), {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_config();
    logic [63:0]       lo;
    logic [63:0]       hi;
    logic [ADDR_W-1:0] base;
    logic [CARE_W-1:0] care;
    logic [LEN_W-1:0]  len;
    case ($urandom_range(0, 9))
      0: len = '0;
      1: len = LEN_W'($urandom_range(PATTERN_MAX_DEF + 1, 31));
      2: len = LEN_W'(PATTERN_MAX_DEF);
      3: len = 1;
      default: len = LEN_W'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 7))
      0: care = '0;
      1, 2: care = CARE_W'($urandom);
      default: care = '1;
    endcase
    case ($urandom_range(0, 7))
      0: lo = '0;
      1: lo = '1;
      default: lo = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 7))
      0: hi = '0;
      1: hi = '1;
      default: hi = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 4))
      0: base = '0;
      1: base = '1;
      2: base = '1 - ADDR_W'($urandom_range(0, 64));
      default: base = {$urandom, $urandom};
    endcase
    program_scan(lo, hi, care, len, base);
  endtask

  // Most regions carry one instance of the pattern, some of them with one pattern byte changed.
  task automatic build_region();
    int eff;
    int kind;
    int pre;
    int pos;
    eff  = board.effective_length();
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      repeat ($urandom_range(100, 200)) append_byte(8'($urandom));
    end else if (kind < 30) begin
      repeat ($urandom_range(1, 20)) append_byte(8'($urandom));
    end else begin
      pre = $urandom_range(0, 12);
      repeat (pre) append_byte(8'($urandom));
      for (int j = 0; j < eff; j++)
        append_byte(board.care[j] ? board.pattern[8*j +: 8] : 8'($urandom));
      if ($urandom_range(0, 4) == 0) begin
        pos = pre + $urandom_range(0, eff - 1);
        region_q[pos] = region_q[pos] ^ 8'($urandom_range(1, 255));
      end
      repeat ($urandom_range(0, 8)) append_byte(8'($urandom));
    end
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    region_q = '{8'h00};
    send_region();
    region_q = '{8'hff};
    send_region();

    program_scan(64'hff, '0, '1, '0, '1);
    region_q = '{8'h12, 8'hff, 8'hff};
    send_region();

    program_scan({$urandom, $urandom}, {$urandom, $urandom}, '0, 5'd31, {$urandom, $urandom});
    region_q = '{8'h00, 8'hff, 8'h5a};
    send_region();

    program_scan({$urandom, $urandom}, {$urandom, $urandom}, 16'hfffc, 5'd2,
                 {$urandom, $urandom});
    region_q = '{8'($urandom), 8'($urandom)};
    send_region();

    program_scan('0, '1, '1, LEN_W'(PATTERN_MAX_DEF), {$urandom, $urandom});
    repeat (8) append_byte(8'h00);
    repeat (8) append_byte(8'hff);
    send_region();

    while (board.scanned < SCAN_ITEMS) begin
      random_config();
      repeat ($urandom_range(1, 6)) begin
        build_region();
        send_region();
      end
    end

    drain();
    board.mismatches += board.pending_q.size();
    if (board.mismatches == 0) begin
      $display("masked_byte_pattern_scan_core verification clean");
    end else begin
      $display("masked_byte_pattern_scan_core verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/mbps_pkg.sv
src/mbps_front.sv
src/mbps_queue.sv
src/mbps_back.sv
src/masked_byte_pattern_scan_core.sv
dv/masked_byte_pattern_scan_core_tb.sv
